>>> design/tpd_pkg.sv
// Shared types, constants and CRC helper for the telemetry packet deframer.
package tpd_pkg;

    localparam int NFIELDS = 9;

    localparam logic [7:0]  START_BYTE    = 8'h02;
    localparam logic [7:0]  END_BYTE      = 8'h03;
    localparam logic [7:0]  CMD_TELEMETRY = 8'h04;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_MSB       = 16'h8000;
    localparam logic [8:0]  POS_MAX       = 9'd511;
    localparam logic [8:0]  FAULT_REL     = 9'd72;
    localparam logic [7:0]  FAULT_NEED    = 8'd74;
    localparam logic [9:0]  MIN_SIZE      = 10'd6;

    // Telemetry field offsets and lengths, relative to the byte after the command
    localparam logic [7:0] FLD_OFF [NFIELDS] = '{8'd0, 8'd2, 8'd4, 8'd8, 8'd20,
                                                 8'd24, 8'd26, 8'd34, 8'd42};
    localparam logic [7:0] FLD_LEN [NFIELDS] = '{8'd2, 8'd2, 8'd4, 8'd4, 8'd4,
                                                 8'd2, 8'd4, 8'd4, 8'd4};

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_START = 3'd2,
        ST_BAD_END   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_CRC   = 3'd5,
        ST_OTHER_CMD = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_byte;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] temp_fet_tenths;
        logic signed [15:0] temp_motor_tenths;
        logic [31:0]        motor_current_bits;
        logic [31:0]        input_current_bits;
        logic [31:0]        input_voltage_bits;
        logic signed [15:0] duty_thousandths;
        logic signed [31:0] electrical_rpm;
        logic [31:0]        amp_hours_bits;
        logic [31:0]        watt_hours_bits;
        logic [7:0]         fault_code;
    } t_result;

    // CRC-16 poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((x & CRC_MSB) != 16'h0000) begin
                x = (x << 1) ^ CRC_POLY;
            end else begin
                x = x << 1;
            end
        end
        return x;
    endfunction

endpackage

>>> design/tpd_if.sv
// Valid/ready channel interfaces for received bytes and decoded results.
interface tpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface tpd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [15:0] temp_fet_tenths;
    logic signed [15:0] temp_motor_tenths;
    logic [31:0]        motor_current_bits;
    logic [31:0]        input_current_bits;
    logic [31:0]        input_voltage_bits;
    logic signed [15:0] duty_thousandths;
    logic signed [31:0] electrical_rpm;
    logic [31:0]        amp_hours_bits;
    logic [31:0]        watt_hours_bits;
    logic [7:0]         fault_code;

    modport source (output valid, output status, output temp_fet_tenths,
                    output temp_motor_tenths, output motor_current_bits,
                    output input_current_bits, output input_voltage_bits,
                    output duty_thousandths, output electrical_rpm,
                    output amp_hours_bits, output watt_hours_bits,
                    output fault_code, input ready);
    modport sink   (input valid, input status, input temp_fet_tenths,
                    input temp_motor_tenths, input motor_current_bits,
                    input input_current_bits, input input_voltage_bits,
                    input duty_thousandths, input electrical_rpm,
                    input amp_hours_bits, input watt_hours_bits,
                    input fault_code, output ready);
endinterface

>>> design/tpd_parser.sv
// Packet state, CRC, field capture and end-of-packet checks.
module tpd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  tpd_pkg::t_byte  i_item,
    output tpd_pkg::t_result o_result
);
    import tpd_pkg::*;

    logic [8:0]  r_pos,   n_pos;
    logic        r_start, n_start;
    logic [7:0]  r_len,   n_len;
    logic [7:0]  r_cmd,   n_cmd;
    logic [7:0]  r_fault, n_fault;
    logic [15:0] r_crc,   n_crc;
    logic [15:0] r_rcrc,  n_rcrc;
    logic [31:0] r_fld [NFIELDS];
    logic [31:0] n_fld [NFIELDS];

    logic [7:0]         b;
    logic [8:0]         len_w;
    logic [8:0]         rel;
    logic               rel_ok;
    logic [9:0]         size;
    logic [9:0]         need;
    t_status            status;
    logic [NFIELDS-1:0] fld_ok;
    logic               fault_ok;

    always_comb begin
        b       = i_item.rx_byte;
        n_start = (r_pos == 9'd0) ? (b == START_BYTE) : r_start;
        n_len   = (r_pos == 9'd1) ? b : r_len;
        n_cmd   = (r_pos == 9'd2) ? b : r_cmd;
        len_w   = {1'b0, n_len};

        // payload spans positions 2 .. 1+L; big-endian CRC follows
        n_crc = r_crc;
        if (r_pos >= 9'd2 && r_pos < len_w + 9'd2) begin
            n_crc = crc_step(r_crc, b);
        end
        n_rcrc = r_rcrc;
        if (r_pos == len_w + 9'd2) begin
            n_rcrc = {b, 8'h00};
        end else if (r_pos == len_w + 9'd3) begin
            n_rcrc = {r_rcrc[15:8], b};
        end

        rel_ok = (r_pos >= 9'd3);
        rel    = r_pos - 9'd3;
        for (int i = 0; i < NFIELDS; i++) begin
            n_fld[i] = r_fld[i];
            if (rel_ok && rel >= {1'b0, FLD_OFF[i]}
                    && rel < {1'b0, FLD_OFF[i]} + {1'b0, FLD_LEN[i]}) begin
                n_fld[i] = {r_fld[i][23:0], b};
            end
        end
        n_fault = (rel_ok && rel == FAULT_REL) ? b : r_fault;
        n_pos   = (r_pos < POS_MAX) ? r_pos + 9'd1 : r_pos;

        size = {1'b0, r_pos} + 10'd1;
        need = {2'b00, n_len} + 10'd4;
        if (size < MIN_SIZE) begin
            status = ST_SHORT;
        end else if (!n_start) begin
            status = ST_BAD_START;
        end else if (b != END_BYTE) begin
            status = ST_BAD_END;
        end else if (size < need) begin
            status = ST_BAD_LEN;
        end else if (n_crc != n_rcrc) begin
            status = ST_BAD_CRC;
        end else if (n_cmd != CMD_TELEMETRY) begin
            status = ST_OTHER_CMD;
        end else begin
            status = ST_OK;
        end

        // a field counts only if it lies wholly inside the telemetry area
        for (int i = 0; i < NFIELDS; i++) begin
            fld_ok[i] = (status == ST_OK)
                && (len_w >= {1'b0, FLD_OFF[i]} + {1'b0, FLD_LEN[i]} + 9'd1);
        end
        fault_ok = (status == ST_OK) && (n_len >= FAULT_NEED);

        o_result.status             = status;
        o_result.temp_fet_tenths    = fld_ok[0] ? n_fld[0][15:0] : 16'h0000;
        o_result.temp_motor_tenths  = fld_ok[1] ? n_fld[1][15:0] : 16'h0000;
        o_result.motor_current_bits = fld_ok[2] ? n_fld[2] : 32'h0;
        o_result.input_current_bits = fld_ok[3] ? n_fld[3] : 32'h0;
        o_result.input_voltage_bits = fld_ok[4] ? n_fld[4] : 32'h0;
        o_result.duty_thousandths   = fld_ok[5] ? n_fld[5][15:0] : 16'h0000;
        o_result.electrical_rpm     = fld_ok[6] ? n_fld[6] : 32'h0;
        o_result.amp_hours_bits     = fld_ok[7] ? n_fld[7] : 32'h0;
        o_result.watt_hours_bits    = fld_ok[8] ? n_fld[8] : 32'h0;
        o_result.fault_code         = fault_ok ? n_fault : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_pos   <= '0;
            r_start <= 1'b0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_fault <= '0;
            r_crc   <= '0;
            r_rcrc  <= '0;
            for (int i = 0; i < NFIELDS; i++) begin
                r_fld[i] <= '0;
            end
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            r_fault <= n_fault;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            for (int i = 0; i < NFIELDS; i++) begin
                r_fld[i] <= n_fld[i];
            end
        end
    end

endmodule

>>> design/telemetry_packet_deframer.sv
// Top level: input register, packet parser and result register.
//
//  channel  dir  item                         taken when
//  i_rx     in   rx_byte, last_byte           i_rx.valid & i_rx.ready
//  o_res    out  status + telemetry fields    o_res.valid & o_res.ready
//
// One byte per cycle sustained while o_res takes results; the parser handles
// the registered byte combinationally (byte-wide CRC update plus end-of-packet
// checks). A result reaches o_res through the input and result registers.
// Bytes that are not last never wait on o_res; a last byte waits in the
// input register only while an earlier result is still held on o_res.
// Reset is synchronous, active low; i_rx.ready is low while it is held.
module telemetry_packet_deframer (
    input logic      i_clk,
    input logic      i_rst_n,
    tpd_in_if.sink   i_rx,
    tpd_out_if.source o_res
);
    import tpd_pkg::*;

    // input register
    logic    r_in_vld;
    t_byte   r_in;
    // result register
    logic    r_out_vld;
    t_result r_out;

    logic    step;      // registered byte goes through the parser this cycle
    logic    take;      // downstream takes the held result
    logic    accept;    // new byte taken from i_rx
    t_result res;

    assign take   = r_out_vld & o_res.ready;
    // a last byte needs room in the result register, others pass freely
    assign step   = r_in_vld & (~r_in.last_byte | ~r_out_vld | o_res.ready);
    assign i_rx.ready = i_rst_n & (~r_in_vld | step);
    assign accept = i_rx.valid & i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (~r_in_vld | step) begin
            r_in_vld <= i_rx.valid;
        end
        if (accept) begin
            r_in.rx_byte   <= i_rx.rx_byte;
            r_in.last_byte <= i_rx.last_byte;
        end
    end

    tpd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step & r_in.last_byte) begin
            r_out_vld <= 1'b1;
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
        if (step & r_in.last_byte) begin
            r_out <= res;
        end
    end

    assign o_res.valid              = r_out_vld;
    assign o_res.status             = r_out.status;
    assign o_res.temp_fet_tenths    = r_out.temp_fet_tenths;
    assign o_res.temp_motor_tenths  = r_out.temp_motor_tenths;
    assign o_res.motor_current_bits = r_out.motor_current_bits;
    assign o_res.input_current_bits = r_out.input_current_bits;
    assign o_res.input_voltage_bits = r_out.input_voltage_bits;
    assign o_res.duty_thousandths   = r_out.duty_thousandths;
    assign o_res.electrical_rpm     = r_out.electrical_rpm;
    assign o_res.amp_hours_bits     = r_out.amp_hours_bits;
    assign o_res.watt_hours_bits    = r_out.watt_hours_bits;
    assign o_res.fault_code         = r_out.fault_code;

endmodule
